// ===== hdl/ilra_pkg.sv =====
// package for the signed 64-bit reduction alu
// types, operation codes and status codes; no dependencies
package ilra_pkg;
  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 7;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TYPE  = 2'd1,
    ST_DIV0  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIX,
    S_OUT
  } state_t;

  // request to the serial arithmetic unit
  typedef struct packed {
    logic start;
    logic is_div;
  } sreq_t;

  typedef struct packed {
    logic done;
  } sresp_t;
endpackage

// ===== hdl/ilra_serial.sv =====
// bit-serial shift-add multiplier and restoring divider; the top feeds the divider magnitudes
// depends on ilra_pkg
module ilra_serial (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ilra_pkg::sreq_t            req,
  input  logic [ilra_pkg::DataW-1:0] a,
  input  logic [ilra_pkg::DataW-1:0] b,
  output ilra_pkg::sresp_t           resp,
  output logic [ilra_pkg::DataW-1:0] prod,
  output logic [ilra_pkg::DataW-1:0] quo,
  output logic [ilra_pkg::DataW-1:0] rem
);
  import ilra_pkg::*;

  logic              busy_r, busy_nxt;
  logic              div_r, div_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [DataW-1:0]  acc_r, acc_nxt;   // product or remainder
  logic [DataW-1:0]  sh_r, sh_nxt;     // multiplier bits or dividend/quotient
  logic [DataW-1:0]  op_r, op_nxt;     // multiplicand or divisor
  logic [DataW:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    op_nxt   = op_r;
    trial    = {acc_r, sh_r[DataW-1]} - {1'b0, op_r};
    resp.done = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      div_nxt  = req.is_div;
      cnt_nxt  = '0;
      acc_nxt  = '0;
      sh_nxt   = req.is_div ? a : b;
      op_nxt   = req.is_div ? b : a;
    end else if (busy_r) begin
      if (div_r) begin
        if (!trial[DataW]) begin
          acc_nxt = trial[DataW-1:0];
          sh_nxt  = {sh_r[DataW-2:0], 1'b1};
        end else begin
          acc_nxt = {acc_r[DataW-2:0], sh_r[DataW-1]};
          sh_nxt  = {sh_r[DataW-2:0], 1'b0};
        end
      end else begin
        // lsb-first multiplier bit, multiplicand shifted left
        if (sh_r[0]) acc_nxt = acc_r + op_r;
        sh_nxt = {1'b0, sh_r[DataW-1:1]};
        op_nxt = {op_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(DataW - 1)) begin
        busy_nxt  = 1'b0;
        resp.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      div_r  <= div_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    op_r  <= op_nxt;
  end

  assign prod = acc_r;
  assign quo  = sh_r;
  assign rem  = acc_r;
endmodule

// ===== hdl/integer_list_reduce_alu_top.sv =====
// top level of the signed 64-bit reduction alu: fold control and output register
// depends on ilra_pkg and ilra_serial
//
// channel  dir  tdata                     tuser
// in_      in   [63:0] operand            [2:0] func, [3] is_number, [4] empty_list
// out_     out  [63:0] result             [1:0] status
//
// add, subtract and the first word go from the request through S_FIX and back to idle
// multiply, divide and modulo run the bit-serial unit, which handles one bit per
// cycle (64 steps), then a result load in S_OUT and a fix-up in S_FIX
// synchronous active-low reset clears the fold state and the output valid
// a pending result holds while out_tready is low; no new request is taken then
module integer_list_reduce_alu_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] operand
  input  logic [4:0]  in_tuser,   // [2:0] func, [3] is_number, [4] empty_list
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] result
  output logic [1:0]  out_tuser   // [1:0] status
);
  import ilra_pkg::*;

  state_t           state_r, state_nxt;
  logic [DataW-1:0] acc_r, acc_nxt;
  logic             seen_r, seen_nxt;
  logic [1:0]       err_r, err_nxt;
  // latched request
  logic [2:0]       func_r, func_nxt;
  logic             last_r, last_nxt;
  logic             first_r, first_nxt;
  logic             neg_r, neg_nxt;       // sign fix after the serial unit
  logic             rsgn_r, rsgn_nxt;     // remainder follows dividend sign
  // output register
  logic             ovalid_r, ovalid_nxt;
  logic [DataW-1:0] odata_r, odata_nxt;
  logic [1:0]       ostat_r, ostat_nxt;

  logic [2:0]       in_func;
  logic [DataW-1:0] x;
  logic [DataW-1:0] mag_a, mag_x;
  logic             x_num, x_empty, take;
  sreq_t            sreq;
  sresp_t           sresp;
  logic [DataW-1:0] prod, quo, rem;

  assign in_func = in_tuser[2:0];
  assign x       = in_tdata;
  assign x_num   = in_tuser[3];
  assign x_empty = in_tuser[4];
  assign mag_a   = acc_r[DataW-1] ? -acc_r : acc_r;
  assign mag_x   = x[DataW-1] ? -x : x;

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign take      = in_tvalid && in_tready;

  ilra_serial u_serial (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (sreq),
    .a    (sreq.is_div ? mag_a : acc_r),
    .b    (sreq.is_div ? mag_x : x),
    .resp (sresp),
    .prod (prod),
    .quo  (quo),
    .rem  (rem)
  );

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    err_nxt    = err_r;
    func_nxt   = func_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    neg_nxt    = neg_r;
    rsgn_nxt   = rsgn_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ostat_nxt  = ostat_r;
    sreq       = '0;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (take) begin
          func_nxt  = in_func;
          last_nxt  = in_tlast;
          first_nxt = !seen_r;
          if (x_empty) begin
            ovalid_nxt = 1'b1;
            ostat_nxt  = ST_OK;
            case (in_func)
              OP_ADD, OP_SUB: odata_nxt = '0;
              OP_MUL, OP_DIV: odata_nxt = DataW'(1);
              default: begin
                odata_nxt = '0;
                ostat_nxt = ST_TYPE;
              end
            endcase
            acc_nxt  = '0;
            seen_nxt = 1'b0;
            err_nxt  = ST_OK;
          end else begin
            seen_nxt  = 1'b1;
            state_nxt = S_FIX;
            if (!x_num) begin
              err_nxt = ST_TYPE;
            end else if (err_r == ST_OK) begin
              if (!seen_r) begin
                acc_nxt = x;
              end else begin
                case (in_func)
                  OP_ADD: acc_nxt = acc_r + x;
                  OP_SUB: acc_nxt = acc_r - x;
                  OP_MUL: begin
                    sreq.start = 1'b1;
                    state_nxt  = S_MUL;
                  end
                  OP_DIV, OP_MOD: begin
                    if (x == '0) begin
                      err_nxt = ST_DIV0;
                    end else begin
                      sreq.start  = 1'b1;
                      sreq.is_div = 1'b1;
                      neg_nxt     = acc_r[DataW-1] ^ x[DataW-1];
                      rsgn_nxt    = acc_r[DataW-1];
                      state_nxt   = S_DIV;
                    end
                  end
                  default: acc_nxt = acc_r;
                endcase
              end
            end
          end
        end
      end
      S_MUL: begin
        if (sresp.done) state_nxt = S_OUT;
      end
      S_DIV: begin
        if (sresp.done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // serial result is registered and valid in the cycle after done
        if (func_r == OP_MUL) acc_nxt = prod;
        else if (func_r == OP_DIV) acc_nxt = neg_r ? -quo : quo;
        else acc_nxt = rsgn_r ? -rem : rem;
        state_nxt = S_FIX;
      end
      S_FIX: begin
        state_nxt = S_IDLE;
        if (last_r) begin
          ovalid_nxt = 1'b1;
          if (err_r != ST_OK) begin
            odata_nxt = '0;
            ostat_nxt = err_r;
          end else begin
            odata_nxt = (first_r && func_r == OP_SUB) ? -acc_r : acc_r;
            ostat_nxt = ST_OK;
          end
          acc_nxt  = '0;
          seen_nxt = 1'b0;
          err_nxt  = ST_OK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      acc_r    <= '0;
      seen_r   <= 1'b0;
      err_r    <= ST_OK;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      err_r    <= err_nxt;
      ovalid_r <= ovalid_nxt;
    end
    func_r  <= func_nxt;
    last_r  <= last_nxt;
    first_r <= first_nxt;
    neg_r   <= neg_nxt;
    rsgn_r  <= rsgn_nxt;
    odata_r <= odata_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ostat_r;
endmodule
